>>> hw/rtl/firdec_pkg.sv
// Shared types and constants for the FIR decimator.
// Used by the RAM-based filter top level and by its port checker.
package firdec_pkg;

    localparam int ACC_BITS   = 64;
    localparam int CMD_BITS   = 2;
    localparam int DECIM_BITS = 9;
    localparam int CNT_BITS   = 8;
    localparam int DECIM_MAX  = 256;

    localparam logic [CMD_BITS-1:0] CMD_PUSH  = 2'd0;
    localparam logic [CMD_BITS-1:0] CMD_COEFF = 2'd1;
    localparam logic [CMD_BITS-1:0] CMD_CLEAR = 2'd2;

    localparam logic REG_TAP_COUNT  = 1'b0;
    localparam logic REG_DECIMATION = 1'b1;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_MAC,
        ST_FLUSH,
        ST_ROUND,
        ST_DONE
    } state_t;

endpackage

>>> hw/rtl/firdec_ram.sv
// Generic single-clock RAM with one write port and one registered read port.
// No dependencies.
module firdec_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

>>> hw/rtl/fir_decimator.sv
// FIR decimation filter: history and coefficients in two RAMs, one shared MAC.
// Depends on firdec_pkg and firdec_ram.
//
// Channel   Direction  Beat content
// s_axis    in         command, sample, coeff_index, coeff_value (tdata)
// m_axis    out        filtered_sample (tdata)
// cfg       in         register write: cfg_index, cfg_wdata
//
// A coefficient write, an ignored command or a push that emits nothing leaves the filter ready for the next beat.
// A push that emits a result is worked by the single multiply-accumulate walking the history
// and coefficient RAMs one tap per cycle, then draining its pipeline, rounding and loading
// the output register.
// After reset and after every clear command the history RAM is zeroed by a pass over all
// MAX_TAPS entries, during which no beat is accepted.
// A finished result waits in the output register while the next beat is accepted; the
// next result holds off the input until the waiting one is taken.
module fir_decimator #(
    parameter int MAX_TAPS    = 64,
    parameter int SAMPLE_BITS = 16,
    localparam int IW     = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1,
    localparam int TC_W   = $clog2(MAX_TAPS + 1),
    localparam int IN_RAW = firdec_pkg::CMD_BITS + 2 * SAMPLE_BITS + IW,
    localparam int IN_W   = ((IN_RAW + 7) / 8) * 8,
    localparam int OUT_W  = ((SAMPLE_BITS + 7) / 8) * 8,
    localparam int CFG_W  = (TC_W > firdec_pkg::DECIM_BITS) ? TC_W : firdec_pkg::DECIM_BITS
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s_tvalid,
    output logic             s_tready,
    // command, sample, coeff_index, coeff_value, zero fill
    input  logic [IN_W-1:0]  s_tdata,
    output logic             m_tvalid,
    input  logic             m_tready,
    // filtered_sample, zero fill
    output logic [OUT_W-1:0] m_tdata,
    input  logic             cfg_we,
    input  logic             cfg_index,
    input  logic [CFG_W-1:0] cfg_wdata
);

    localparam int SB     = SAMPLE_BITS;
    localparam int SMP_LO = firdec_pkg::CMD_BITS;
    localparam int IDX_LO = SMP_LO + SB;
    localparam int CV_LO  = IDX_LO + IW;
    localparam int AB     = firdec_pkg::ACC_BITS;
    localparam int CB     = firdec_pkg::CNT_BITS;
    localparam logic signed [AB-1:0] HALF   = AB'(64'sd1 <<< (SB - 2));
    localparam logic signed [AB-1:0] SAT_HI = AB'((64'sd1 <<< (SB - 1)) - 64'sd1);
    localparam logic signed [AB-1:0] SAT_LO = AB'(-(64'sd1 <<< (SB - 1)));

    firdec_pkg::state_t state_reg, state_next;

    logic [firdec_pkg::CMD_BITS-1:0] cmd;
    logic [SB-1:0]                   in_sample;
    logic [IW-1:0]                   in_idx;
    logic [SB-1:0]                   in_coeff;

    logic [TC_W-1:0]                      tap_count_reg;
    logic [firdec_pkg::DECIM_BITS-1:0]    decim_reg;
    logic [TC_W-1:0]                      taps_eff;
    logic [IW-1:0]                        taps_m1;
    logic [CB-1:0]                        reload;

    logic [IW-1:0] clr_reg, clr_next;
    logic [IW-1:0] wp_reg, wp_next;
    logic [CB-1:0] cnt_reg, cnt_next;
    logic [IW-1:0] k_reg, k_next;
    logic [IW-1:0] h_reg, h_next;
    logic          rd_vld_reg, rd_vld_next;
    logic          prod_vld_reg, prod_vld_next;
    logic          out_vld_reg, out_vld_next;

    logic signed [AB-1:0]     acc_reg, acc_next;
    logic signed [2*SB-1:0]   prod_reg, prod_next;
    logic signed [AB-1:0]     round_reg, round_next;
    logic [SB-1:0]            out_data_reg, out_data_next;
    logic signed [AB-1:0]     shifted;
    logic [SB-1:0]            sat_val;

    logic in_acc;
    logic stale;
    logic is_push;
    logic fire;
    logic is_clear;
    logic idx_ok;
    logic clr_last;
    logic k_last;
    logic out_load;

    logic          hist_we;
    logic [IW-1:0] hist_waddr;
    logic [SB-1:0] hist_wdata;
    logic [SB-1:0] hist_rdata;
    logic          coef_we;
    logic [SB-1:0] coef_rdata;

    assign cmd       = s_tdata[firdec_pkg::CMD_BITS-1:0];
    assign in_sample = s_tdata[SMP_LO +: SB];
    assign in_idx    = s_tdata[IDX_LO +: IW];
    assign in_coeff  = s_tdata[CV_LO +: SB];

    always_comb
    begin
        if (tap_count_reg == '0)
        begin
            taps_eff = TC_W'(1);
        end
        else if (tap_count_reg > TC_W'(MAX_TAPS))
        begin
            taps_eff = TC_W'(MAX_TAPS);
        end
        else
        begin
            taps_eff = tap_count_reg;
        end
        if (decim_reg == '0)
        begin
            reload = '0;
        end
        else if (decim_reg > firdec_pkg::DECIM_BITS'(firdec_pkg::DECIM_MAX))
        begin
            reload = CB'(firdec_pkg::DECIM_MAX - 1);
        end
        else
        begin
            reload = CB'(decim_reg - firdec_pkg::DECIM_BITS'(1));
        end
    end

    assign taps_m1  = IW'(taps_eff - TC_W'(1));
    assign in_acc   = s_tvalid && s_tready;
    assign stale    = TC_W'(wp_reg) >= taps_eff;
    assign is_push  = in_acc && (cmd == firdec_pkg::CMD_PUSH) && !stale;
    assign fire     = is_push && (cnt_reg == '0);
    assign is_clear = in_acc && (cmd == firdec_pkg::CMD_CLEAR);
    assign idx_ok   = {1'b0, in_idx} < (IW + 1)'(MAX_TAPS);
    assign clr_last = clr_reg == IW'(MAX_TAPS - 1);
    assign k_last   = k_reg == taps_m1;
    assign out_load = (state_reg == firdec_pkg::ST_DONE) && (!out_vld_reg || m_tready);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            firdec_pkg::ST_CLEAR:
            begin
                if (clr_last)
                begin
                    state_next = firdec_pkg::ST_IDLE;
                end
            end
            firdec_pkg::ST_IDLE:
            begin
                if (is_clear)
                begin
                    state_next = firdec_pkg::ST_CLEAR;
                end
                else if (fire)
                begin
                    state_next = firdec_pkg::ST_MAC;
                end
            end
            firdec_pkg::ST_MAC:
            begin
                if (k_last)
                begin
                    state_next = firdec_pkg::ST_FLUSH;
                end
            end
            firdec_pkg::ST_FLUSH:
            begin
                if (!rd_vld_reg && !prod_vld_reg)
                begin
                    state_next = firdec_pkg::ST_ROUND;
                end
            end
            firdec_pkg::ST_ROUND:
            begin
                state_next = firdec_pkg::ST_DONE;
            end
            firdec_pkg::ST_DONE:
            begin
                if (out_load)
                begin
                    state_next = firdec_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = firdec_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        s_tready   = state_reg == firdec_pkg::ST_IDLE;
        hist_we    = (state_reg == firdec_pkg::ST_CLEAR) || is_push;
        hist_waddr = (state_reg == firdec_pkg::ST_CLEAR) ? clr_reg : wp_reg;
        hist_wdata = (state_reg == firdec_pkg::ST_CLEAR) ? '0 : in_sample;
        coef_we    = in_acc && (cmd == firdec_pkg::CMD_COEFF) && idx_ok;
        m_tvalid   = out_vld_reg;
        m_tdata    = OUT_W'(out_data_reg);
    end

    assign shifted = round_reg >>> (SB - 1);

    always_comb
    begin
        if (shifted > SAT_HI)
        begin
            sat_val = SAT_HI[SB-1:0];
        end
        else if (shifted < SAT_LO)
        begin
            sat_val = SAT_LO[SB-1:0];
        end
        else
        begin
            sat_val = shifted[SB-1:0];
        end
    end

    always_comb
    begin
        clr_next      = ((state_reg == firdec_pkg::ST_CLEAR) && !clr_last) ? clr_reg + 1'b1 : '0;
        wp_next       = wp_reg;
        cnt_next      = cnt_reg;
        k_next        = k_reg;
        h_next        = h_reg;
        acc_next      = acc_reg;
        prod_next     = prod_reg;
        round_next    = round_reg;
        out_data_next = out_data_reg;
        rd_vld_next   = state_reg == firdec_pkg::ST_MAC;
        prod_vld_next = rd_vld_reg;
        out_vld_next  = out_load ? 1'b1 : (m_tready ? 1'b0 : out_vld_reg);

        if (is_clear)
        begin
            wp_next  = '0;
            cnt_next = '0;
        end
        if (is_push)
        begin
            wp_next  = (wp_reg == taps_m1) ? '0 : wp_reg + 1'b1;
            cnt_next = (cnt_reg != '0) ? cnt_reg - 1'b1 : reload;
        end
        if (fire)
        begin
            k_next   = '0;
            h_next   = wp_reg;
            acc_next = '0;
        end
        if (state_reg == firdec_pkg::ST_MAC)
        begin
            k_next = k_reg + 1'b1;
            h_next = (h_reg == '0) ? taps_m1 : h_reg - 1'b1;
        end
        if (rd_vld_reg)
        begin
            prod_next = $signed(coef_rdata) * $signed(hist_rdata);
        end
        if (prod_vld_reg)
        begin
            acc_next = acc_reg + AB'(prod_reg);
        end
        if (state_reg == firdec_pkg::ST_ROUND)
        begin
            round_next = acc_reg + HALF;
        end
        if (out_load)
        begin
            out_data_next = sat_val;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= firdec_pkg::ST_CLEAR;
            clr_reg       <= '0;
            wp_reg        <= '0;
            cnt_reg       <= '0;
            k_reg         <= '0;
            h_reg         <= '0;
            rd_vld_reg    <= 1'b0;
            prod_vld_reg  <= 1'b0;
            out_vld_reg   <= 1'b0;
            tap_count_reg <= TC_W'(1);
            decim_reg     <= firdec_pkg::DECIM_BITS'(1);
        end
        else
        begin
            state_reg    <= state_next;
            clr_reg      <= clr_next;
            wp_reg       <= wp_next;
            cnt_reg      <= cnt_next;
            k_reg        <= k_next;
            h_reg        <= h_next;
            rd_vld_reg   <= rd_vld_next;
            prod_vld_reg <= prod_vld_next;
            out_vld_reg  <= out_vld_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    firdec_pkg::REG_TAP_COUNT:  tap_count_reg <= cfg_wdata[TC_W-1:0];
                    firdec_pkg::REG_DECIMATION:
                        decim_reg <= cfg_wdata[firdec_pkg::DECIM_BITS-1:0];
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg      <= acc_next;
        prod_reg     <= prod_next;
        round_reg    <= round_next;
        out_data_reg <= out_data_next;
    end

    firdec_ram #(
        .WIDTH (SB),
        .DEPTH (MAX_TAPS)
    ) u_hist_ram (
        .clk   (clk),
        .we    (hist_we),
        .waddr (hist_waddr),
        .wdata (hist_wdata),
        .raddr (h_reg),
        .rdata (hist_rdata)
    );

    firdec_ram #(
        .WIDTH (SB),
        .DEPTH (MAX_TAPS)
    ) u_coef_ram (
        .clk   (clk),
        .we    (coef_we),
        .waddr (in_idx),
        .wdata (in_coeff),
        .raddr (k_reg),
        .rdata (coef_rdata)
    );

endmodule

>>> hw/rtl/firdec_checker.sv
// Port-level checker for the FIR decimator, attached by the bind statement below.
// Depends on firdec_pkg and the fir_decimator top level.
module firdec_checker #(
    parameter int IN_W  = 40,
    parameter int OUT_W = 16
) (
    input logic             clk,
    input logic             rst_n,
    input logic             s_tvalid,
    input logic             s_tready,
    input logic [IN_W-1:0]  s_tdata,
    input logic             m_tvalid,
    input logic             m_tready,
    input logic [OUT_W-1:0] m_tdata
);

    logic [firdec_pkg::CMD_BITS-1:0] cmd;

    assign cmd = s_tdata[firdec_pkg::CMD_BITS-1:0];

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("Result beat dropped while stalled.");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> $stable(m_tdata))
        else $error("Result beat changed while stalled.");

    a_result_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> !$past(s_tready))
        else $error("A new result appeared without the filter having been busy.");

    a_clear_busy: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && (cmd == firdec_pkg::CMD_CLEAR) |=> !s_tready)
        else $error("Input accepted during the history clearing pass.");

    a_coeff_quick: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && (cmd == firdec_pkg::CMD_COEFF) |=> s_tready)
        else $error("Coefficient write did not complete in one cycle.");

endmodule

bind fir_decimator firdec_checker #(
    .IN_W  (IN_W),
    .OUT_W (OUT_W)
) u_firdec_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
